// ----- hdl/cpd_column_normalizer_macros.svh -----
// Assertion macros used by the column normalizer top level.
`ifndef CPD_COLUMN_NORMALIZER_MACROS_SVH
`define CPD_COLUMN_NORMALIZER_MACROS_SVH

// Same-cycle implication, checked at every rising clk outside reset.
`define CPD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpd_column_normalizer: same-cycle check failed");

// Next-cycle implication, checked at every rising clk outside reset.
`define CPD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpd_column_normalizer: next-cycle check failed");

`endif

// ----- hdl/cpdcn_pkg.sv -----
// Shared types, codes and chain tables of the column normalizer.
package cpdcn_pkg;

  localparam int IDX_W = 6;

  localparam logic [2:0] TGT_A  = 3'd0;
  localparam logic [2:0] TGT_B  = 3'd1;
  localparam logic [2:0] TGT_C  = 3'd2;
  localparam logic [2:0] TGT_AA = 3'd3;
  localparam logic [2:0] TGT_BB = 3'd4;
  localparam logic [2:0] TGT_CC = 3'd5;

  localparam logic [1:0] FLD_RB = 2'd0;
  localparam logic [1:0] FLD_RC = 2'd1;
  localparam logic [1:0] FLD_IB = 2'd2;
  localparam logic [1:0] FLD_IC = 2'd3;

  localparam logic OPC_LOAD = 1'b0;

  typedef enum logic [3:0] {
    OP_NONE       = 4'd0,
    OP_CLEAR      = 4'd1,
    OP_CAPTURE    = 4'd2,
    OP_SQRT_INIT  = 4'd3,
    OP_SQRT_STEP  = 4'd4,
    OP_SQRT_SAVE  = 4'd5,
    OP_DIV_INIT   = 4'd6,
    OP_DIV_STEP   = 4'd7,
    OP_DIV_SAVE   = 4'd8,
    OP_LOAD_WRITE = 4'd9,
    OP_READ       = 4'd10,
    OP_MUL        = 4'd11,
    OP_SAT        = 4'd12,
    OP_OUT        = 4'd13
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       half;
    logic [1:0] step;
    logic       mul_issue;
    logic       mul_acc;
    logic [1:0] part;
  } cmd_t;

  typedef struct packed {
    logic       opcode;
    logic [2:0] chain_len;
    logic       clear_last;
    logic       out_free;
  } status_t;

  function automatic logic [2:0] chain_len(input logic [2:0] tgt);
    logic [2:0] n;
    case (tgt)
      TGT_A:   n = 3'd2;
      TGT_B:   n = 3'd1;
      TGT_C:   n = 3'd1;
      TGT_AA:  n = 3'd4;
      TGT_BB:  n = 3'd2;
      TGT_CC:  n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // {use row index, table field}
  function automatic logic [2:0] chain_step(input logic [2:0] tgt, input logic [1:0] step);
    logic [2:0] s;
    case (tgt)
      TGT_A:   s = (step == 2'd0) ? {1'b0, FLD_RB} : {1'b0, FLD_RC};
      TGT_B:   s = {1'b0, FLD_IB};
      TGT_C:   s = {1'b0, FLD_IC};
      TGT_AA: begin
        case (step)
          2'd0:    s = {1'b1, FLD_RB};
          2'd1:    s = {1'b1, FLD_RC};
          2'd2:    s = {1'b0, FLD_RB};
          default: s = {1'b0, FLD_RC};
        endcase
      end
      TGT_BB:  s = {(step == 2'd0), FLD_IB};
      TGT_CC:  s = {(step == 2'd0), FLD_IC};
      default: s = {1'b0, FLD_RB};
    endcase
    return s;
  endfunction

endpackage

// ----- hdl/cpdcn_ctrl.sv -----
// Controller state machine of the column normalizer.
module cpdcn_ctrl #(
  parameter int VALUE_WIDTH = 48,
  parameter int FRAC_BITS   = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  cpdcn_pkg::status_t status,
  output cpdcn_pkg::cmd_t    cmd
);
  import cpdcn_pkg::*;

  localparam int XW   = VALUE_WIDTH - 1 + FRAC_BITS;
  localparam int XE   = XW + (XW % 2);
  localparam int SW   = XE / 2;
  localparam int QW   = 2 * FRAC_BITS + 1;
  localparam int CMAX = (SW > QW) ? SW : QW;
  localparam int CW   = $clog2(CMAX + 1);

  typedef enum logic [13:0] {
    S_CLEAR    = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_DISPATCH = 14'b00000000000100,
    S_SQ_INIT  = 14'b00000000001000,
    S_SQ_STEP  = 14'b00000000010000,
    S_SQ_SAVE  = 14'b00000000100000,
    S_DV_INIT  = 14'b00000001000000,
    S_DV_STEP  = 14'b00000010000000,
    S_DV_SAVE  = 14'b00000100000000,
    S_LD_WRITE = 14'b00001000000000,
    S_RD       = 14'b00010000000000,
    S_MUL      = 14'b00100000000000,
    S_SAT      = 14'b01000000000000,
    S_OUT      = 14'b10000000000000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          half, half_next;
  logic [1:0]    step, step_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      half  <= 1'b0;
      step  <= 2'd0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      half  <= half_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    half_next  = half;
    step_next  = step;
    cmd        = '0;
    cmd.op     = OP_NONE;
    cmd.half   = half;
    cmd.step   = step;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_CAPTURE;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status.opcode == OPC_LOAD) begin
          half_next  = 1'b0;
          state_next = S_SQ_INIT;
        end else if (status.chain_len == 3'd0) begin
          state_next = S_OUT;
        end else begin
          step_next  = 2'd0;
          state_next = S_RD;
        end
      end
      S_SQ_INIT: begin
        cmd.op     = OP_SQRT_INIT;
        cnt_next   = '0;
        state_next = S_SQ_STEP;
      end
      S_SQ_STEP: begin
        cmd.op   = OP_SQRT_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(SW - 1)) state_next = S_SQ_SAVE;
      end
      S_SQ_SAVE: begin
        cmd.op    = OP_SQRT_SAVE;
        half_next = ~half;
        state_next = half ? S_DV_INIT : S_SQ_INIT;
      end
      S_DV_INIT: begin
        cmd.op     = OP_DIV_INIT;
        cnt_next   = '0;
        state_next = S_DV_STEP;
      end
      S_DV_STEP: begin
        cmd.op   = OP_DIV_STEP;
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(QW - 1)) state_next = S_DV_SAVE;
      end
      S_DV_SAVE: begin
        cmd.op     = OP_DIV_SAVE;
        half_next  = ~half;
        state_next = half ? S_LD_WRITE : S_DV_INIT;
      end
      S_LD_WRITE: begin
        cmd.op     = OP_LOAD_WRITE;
        state_next = S_IDLE;
      end
      S_RD: begin
        cmd.op     = OP_READ;
        cnt_next   = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op        = OP_MUL;
        cmd.part      = cnt[1:0];
        cmd.mul_issue = (cnt < CW'(4));
        cmd.mul_acc   = (cnt != '0);
        cnt_next      = cnt + 1'b1;
        if (cnt == CW'(4)) state_next = S_SAT;
      end
      S_SAT: begin
        cmd.op    = OP_SAT;
        step_next = step + 2'd1;
        state_next = ((3'(step) + 3'd1) == status.chain_len) ? S_OUT : S_RD;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hdl/cpdcn_datapath.sv -----
// Datapath of the column normalizer: root and reciprocal table, root, divide and multiply units.
module cpdcn_datapath #(
  parameter int RANK_MAX    = 64,
  parameter int VALUE_WIDTH = 48,
  parameter int FRAC_BITS   = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cpdcn_pkg::cmd_t               cmd,
  output cpdcn_pkg::status_t            status,
  input  logic                          opcode,
  input  logic [2:0]                    target_matrix,
  input  logic [cpdcn_pkg::IDX_W-1:0]   row_index,
  input  logic [cpdcn_pkg::IDX_W-1:0]   column_index,
  input  logic signed [VALUE_WIDTH-1:0] first_value,
  input  logic signed [VALUE_WIDTH-1:0] second_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] scaled_value,
  output logic                          saturated_flag
);
  import cpdcn_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int AW = (RANK_MAX > 1) ? $clog2(RANK_MAX) : 1;
  localparam int XW = VW - 1 + FRAC_BITS;
  localparam int XE = XW + (XW % 2);
  localparam int SW = XE / 2;
  localparam int RW = SW + 3;
  localparam int QW = 2 * FRAC_BITS + 1;
  localparam int MW = (SW > VW) ? SW : VW;
  localparam int MQ = (QW > VW) ? QW : VW;
  localparam int HW = (VW + 1) / 2;
  localparam int PW = 2 * VW;
  localparam int TW = 4 * VW;

  localparam logic [VW-1:0] VMAX    = {1'b0, {(VW - 1){1'b1}}};
  localparam logic [VW-1:0] VSIGN   = {1'b1, {(VW - 1){1'b0}}};
  localparam logic [VW-1:0] ONE_VAL =
    (FRAC_BITS >= VW - 1) ? VMAX : VW'(64'd1 << FRAC_BITS);
  localparam logic [10:0]   RANK_W  = 11'(RANK_MAX);

  function automatic logic [AW-1:0] wrap_index(input logic [IDX_W-1:0] idx);
    logic [10:0] r;
    r = '0;
    for (int i = IDX_W - 1; i >= 0; i--) begin
      r = {r[9:0], idx[i]};
      if (r >= RANK_W) r = r - RANK_W;
    end
    return r[AW-1:0];
  endfunction

  // captured request
  logic                 op_q;
  logic [2:0]           tgt_q;
  logic [AW-1:0]        row_q, col_q;
  logic signed [VW-1:0] first_q, second_q;

  // table
  logic [TW-1:0] tbl [RANK_MAX];
  logic [TW-1:0] tbl_rdata, tbl_wdata;
  logic [AW-1:0] tbl_waddr, tbl_raddr, clr_ptr;
  logic          tbl_we, tbl_re;
  logic [1:0]    fsel;
  logic [2:0]    step_info;
  logic          both_pos;

  // root and divide units
  logic [XE-1:0] sq_x;
  logic [RW-1:0] sq_rem, sq_cat, sq_trial;
  logic [SW-1:0] sq_root;
  logic          sq_ge;
  logic [VW-1:0] sq_clip;
  logic [VW-1:0] root_b, root_c, rec_b, rec_c;
  logic [VW-1:0] dv_d;
  logic [VW:0]   dv_rem, dv_cat;
  logic [QW-1:0] dv_q;
  logic          dv_first, dv_ge;
  logic [VW-1:0] dv_clip;

  // scale chain
  logic          neg, sat;
  logic [VW-1:0] mag, factor;
  logic [HW-1:0] a_part, b_part;
  logic [2*HW-1:0] pp;
  logic [1:0]    pp_sh;
  logic [PW-1:0] acc, pp_wide, acc_sh, limit;

  assign status.opcode     = op_q;
  assign status.chain_len  = chain_len(tgt_q);
  assign status.clear_last = (clr_ptr == AW'(RANK_MAX - 1));
  assign status.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAPTURE) begin
      op_q     <= opcode;
      tgt_q    <= target_matrix;
      row_q    <= wrap_index(row_index);
      col_q    <= wrap_index(column_index);
      first_q  <= first_value;
      second_q <= second_value;
      neg      <= first_value[VW-1];
      mag      <= first_value[VW-1] ? VW'(-first_value) : VW'(first_value);
      sat      <= 1'b0;
    end else if (cmd.op == OP_SAT) begin
      if (acc_sh > limit) begin
        mag <= limit[VW-1:0];
        sat <= 1'b1;
      end else begin
        mag <= acc_sh[VW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (cmd.op == OP_CLEAR) begin
      clr_ptr <= clr_ptr + 1'b1;
    end
  end

  assign both_pos = !first_q[VW-1] && (first_q != '0) && !second_q[VW-1] && (second_q != '0);
  assign step_info = chain_step(tgt_q, cmd.step);
  assign tbl_we    = (cmd.op == OP_CLEAR) || (cmd.op == OP_LOAD_WRITE);
  assign tbl_waddr = (cmd.op == OP_CLEAR) ? clr_ptr : col_q;
  assign tbl_wdata = ((cmd.op == OP_LOAD_WRITE) && both_pos) ?
                     {rec_c, rec_b, root_c, root_b} : {4{ONE_VAL}};
  assign tbl_re    = (cmd.op == OP_READ);
  assign tbl_raddr = step_info[2] ? row_q : col_q;

  always_ff @(posedge clk) begin
    if (tbl_we) tbl[tbl_waddr] <= tbl_wdata;
    if (tbl_re) begin
      tbl_rdata <= tbl[tbl_raddr];
      fsel      <= step_info[1:0];
    end
  end

  // digit-by-digit square root, one result bit per step
  assign sq_cat   = {sq_rem[RW-3:0], sq_x[XE-1 -: 2]};
  assign sq_trial = RW'({sq_root, 2'b01});
  assign sq_ge    = (sq_cat >= sq_trial);
  assign sq_clip  = (MW'(sq_root) > MW'(VMAX)) ? VMAX : VW'(sq_root);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SQRT_INIT: begin
        sq_x    <= XE'($unsigned(cmd.half ? second_q : first_q)) << FRAC_BITS;
        sq_rem  <= '0;
        sq_root <= '0;
      end
      OP_SQRT_STEP: begin
        sq_x    <= sq_x << 2;
        sq_rem  <= sq_ge ? (sq_cat - sq_trial) : sq_cat;
        sq_root <= {sq_root[SW-2:0], sq_ge};
      end
      OP_SQRT_SAVE: begin
        if (cmd.half) root_c <= sq_clip;
        else          root_b <= sq_clip;
      end
      default: ;
    endcase
  end

  // restoring divide of one by the root, one quotient bit per step
  assign dv_cat  = {dv_rem[VW-1:0], dv_first};
  assign dv_ge   = (dv_cat >= {1'b0, dv_d});
  assign dv_clip = (MQ'(dv_q) > MQ'(VMAX)) ? VMAX : VW'(dv_q);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_DIV_INIT: begin
        dv_d     <= cmd.half ? root_c : root_b;
        dv_rem   <= '0;
        dv_q     <= '0;
        dv_first <= 1'b1;
      end
      OP_DIV_STEP: begin
        dv_rem   <= dv_ge ? (dv_cat - {1'b0, dv_d}) : dv_cat;
        dv_q     <= {dv_q[QW-2:0], dv_ge};
        dv_first <= 1'b0;
      end
      OP_DIV_SAVE: begin
        if (cmd.half) rec_c <= dv_clip;
        else          rec_b <= dv_clip;
      end
      default: ;
    endcase
  end

  // multiply by four half-width partial products
  assign factor = tbl_rdata[fsel * VW +: VW];
  assign a_part = cmd.part[0] ? HW'(mag[VW-1:HW]) : mag[HW-1:0];
  assign b_part = cmd.part[1] ? HW'(factor[VW-1:HW]) : factor[HW-1:0];

  always_comb begin
    case (pp_sh)
      2'd0:    pp_wide = PW'(pp);
      2'd1:    pp_wide = PW'(pp) << HW;
      default: pp_wide = PW'(pp) << (2 * HW);
    endcase
  end

  assign acc_sh = acc >> FRAC_BITS;
  assign limit  = neg ? PW'(VSIGN) : PW'(VMAX);

  always_ff @(posedge clk) begin
    if (cmd.op == OP_READ) begin
      acc <= '0;
    end else if (cmd.op == OP_MUL) begin
      if (cmd.mul_issue) begin
        pp    <= a_part * b_part;
        pp_sh <= 2'(cmd.part[0]) + 2'(cmd.part[1]);
      end
      if (cmd.mul_acc) acc <= acc + pp_wide;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      scaled_value   <= neg ? $signed(VW'(-mag)) : $signed(mag);
      saturated_flag <= sat;
    end
  end

endmodule

// ----- hdl/cpd_column_normalizer.sv -----
// Column normalizer top level: controller and datapath.
// Takes one request at a time. After reset the block sets every column's
// roots and reciprocals to 1.0 and holds in_stall high meanwhile. A scale
// request runs a chain of multiplies whose length depends on its target (0
// for unknown targets, 1 for B and C, 2 for A, B'B and C'C, 4 for A'A); each
// multiply runs four half-width partial products through one multiplier and
// then saturates. A load request runs one bit-serial root unit of S =
// ceil((VALUE_WIDTH - 1 + FRAC_BITS) / 2) steps and one bit-serial divider,
// twice each. A finished result waits in the output register while the next
// request is accepted.
`include "cpd_column_normalizer_macros.svh"

module cpd_column_normalizer #(
  parameter int RANK_MAX    = 64,
  parameter int VALUE_WIDTH = 48,
  parameter int FRAC_BITS   = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [2:0]                    target_matrix,
  input  logic [cpdcn_pkg::IDX_W-1:0]   row_index,
  input  logic [cpdcn_pkg::IDX_W-1:0]   column_index,
  input  logic signed [VALUE_WIDTH-1:0] first_value,
  input  logic signed [VALUE_WIDTH-1:0] second_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] scaled_value,
  output logic                          saturated_flag
);
  import cpdcn_pkg::*;

  cmd_t    cmd;
  status_t status;

  cpdcn_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  cpdcn_datapath #(
    .RANK_MAX    (RANK_MAX),
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .opcode         (opcode),
    .target_matrix  (target_matrix),
    .row_index      (row_index),
    .column_index   (column_index),
    .first_value    (first_value),
    .second_value   (second_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .scaled_value   (scaled_value),
    .saturated_flag (saturated_flag)
  );

  `CPD_ASSERT_NXT(a_one_request_in_flight, in_valid && !in_stall, in_stall)
  `CPD_ASSERT_IMP(a_no_result_overwrite, cmd.op == OP_OUT, !out_valid || !out_stall)
  `CPD_ASSERT_IMP(a_clear_after_reset, $fell(rst), in_stall)

endmodule

// ----- tb/cpd_column_normalizer_tb.sv -----
// Self-checking testbench for the column normalizer: directed and random load and scale requests.
`timescale 1ns / 1ps

module cpd_column_normalizer_tb;
  import cpdcn_pkg::*;

  localparam int VW = 48;
  localparam int FB = 24;
  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VNEG = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] ONE = 48'd1 << FB;
  localparam logic OPC_SCALE = 1'b1;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_LEN = 400;

  typedef struct {
    logic opc;
    logic [2:0] tgt;
    logic [5:0] row;
    logic [5:0] col;
    logic [VW-1:0] v1;
    logic [VW-1:0] v2;
  } request_t;

  typedef struct {
    logic [VW-1:0] val;
    logic sat;
  } scaled_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = 1'b0;
  logic [2:0] target_matrix = 3'd0;
  logic [5:0] row_index = 6'd0;
  logic [5:0] column_index = 6'd0;
  logic signed [VW-1:0] first_value = '0;
  logic signed [VW-1:0] second_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VW-1:0] scaled_value;
  logic saturated_flag;

  request_t pending_requests[$];
  scaled_t scaled_expected[$];
  logic [VW-1:0] root_b[64], root_c[64], inv_b[64], inv_c[64];
  int errors = 0, loads_sent = 0, scales_sent = 0, results_seen = 0, sat_seen = 0;
  int send_gap = 0, recv_gap = 0, hold_left = 0, idle_cycles = 0;
  bit pressure_done = 0, stimulus_done = 0;

  cpd_column_normalizer dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [VW-1:0] col_root(logic [VW-1:0] raw);
    logic [127:0] x;
    logic [63:0] r, c;
    int k;
    if (raw == 0 || raw[VW-1]) return '0;
    x = {80'd0, raw} << FB;
    r = 0;
    for (k = 63; k >= 0; k--) begin
      c = r | (64'd1 << k);
      if ({64'd0, c} * {64'd0, c} <= x) r = c;
    end
    return (r > {16'd0, VMAX}) ? VMAX : r[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] col_recip(logic [VW-1:0] d);
    logic [127:0] q;
    q = (128'd1 << (2 * FB)) / {80'd0, d};
    return (q > {80'd0, VMAX}) ? VMAX : q[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] mul_step(logic [VW-1:0] mag, bit neg, logic [VW-1:0] f,
                                              inout bit sat);
    logic [127:0] p;
    logic [VW-1:0] lim;
    p = ({80'd0, mag} * {80'd0, f}) >> FB;
    lim = neg ? VNEG : VMAX;
    if (p > {80'd0, lim}) begin
      sat = 1;
      return lim;
    end
    return p[VW-1:0];
  endfunction

  task automatic apply_request(request_t r);
    logic [VW-1:0] b, c, mag;
    bit neg, sat;
    scaled_t e;
    if (r.opc == OPC_LOAD) begin
      b = col_root(r.v1);
      c = col_root(r.v2);
      if (b != 0 && c != 0) begin
        root_b[r.col] = b;
        root_c[r.col] = c;
        inv_b[r.col] = col_recip(b);
        inv_c[r.col] = col_recip(c);
      end else begin
        root_b[r.col] = ONE;
        root_c[r.col] = ONE;
        inv_b[r.col] = ONE;
        inv_c[r.col] = ONE;
      end
      loads_sent++;
      return;
    end
    neg = r.v1[VW-1];
    mag = neg ? -r.v1 : r.v1;
    sat = 0;
    case (r.tgt)
      TGT_A: begin
        mag = mul_step(mag, neg, root_b[r.col], sat);
        mag = mul_step(mag, neg, root_c[r.col], sat);
      end
      TGT_B: mag = mul_step(mag, neg, inv_b[r.col], sat);
      TGT_C: mag = mul_step(mag, neg, inv_c[r.col], sat);
      TGT_AA: begin
        mag = mul_step(mag, neg, root_b[r.row], sat);
        mag = mul_step(mag, neg, root_c[r.row], sat);
        mag = mul_step(mag, neg, root_b[r.col], sat);
        mag = mul_step(mag, neg, root_c[r.col], sat);
      end
      TGT_BB: begin
        mag = mul_step(mag, neg, inv_b[r.row], sat);
        mag = mul_step(mag, neg, inv_b[r.col], sat);
      end
      TGT_CC: begin
        mag = mul_step(mag, neg, inv_c[r.row], sat);
        mag = mul_step(mag, neg, inv_c[r.col], sat);
      end
      default: ;
    endcase
    e.val = neg ? -mag : mag;
    e.sat = sat;
    scaled_expected.push_back(e);
    scales_sent++;
  endtask

  function automatic logic [VW-1:0] rand_value();
    logic [63:0] w;
    w = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) w = $signed(w) >>> $urandom_range(0, 46);
    return w[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] rand_diag();
    logic [VW-1:0] w;
    w = rand_value();
    w[VW-1] = 1'b0;
    return w >> $urandom_range(0, 40);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic add_request(logic opc, logic [2:0] tgt, logic [5:0] row, logic [5:0] col,
                             logic [VW-1:0] v1, logic [VW-1:0] v2);
    request_t r;
    r.opc = opc;
    r.tgt = tgt;
    r.row = row;
    r.col = col;
    r.v1 = v1;
    r.v2 = v2;
    pending_requests.push_back(r);
  endtask

  initial begin
    int i, t;
    for (i = 0; i < 64; i++) begin
      root_b[i] = ONE;
      root_c[i] = ONE;
      inv_b[i] = ONE;
      inv_c[i] = ONE;
    end
    for (t = 0; t < 8; t++) add_request(OPC_SCALE, 3'(t), 6'd63, 6'd0, VMAX, '0);
    add_request(OPC_SCALE, TGT_A, 6'd0, 6'd63, VNEG, VMAX);
    add_request(OPC_LOAD, 3'd7, 6'd63, 6'd63, VMAX, VMAX);
    add_request(OPC_LOAD, TGT_A, 6'd0, 6'd0, 48'd1, 48'd1);
    add_request(OPC_LOAD, TGT_A, 6'd0, 6'd1, '0, ONE);
    add_request(OPC_LOAD, TGT_A, 6'd0, 6'd2, ONE, VNEG);
    add_request(OPC_LOAD, TGT_A, 6'd0, 6'd3, 48'd4 << FB, 48'd9 << FB);
    for (t = 0; t < 8; t++) add_request(OPC_SCALE, 3'(t), 6'd63, 6'd0, VNEG, VMAX);
    add_request(OPC_SCALE, TGT_AA, 6'd63, 6'd63, '1, '0);
    add_request(OPC_SCALE, TGT_BB, 6'd3, 6'd3, ONE, '0);
    add_request(OPC_SCALE, TGT_CC, 6'd2, 6'd1, '0, '0);
    for (i = 0; i < 1850; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        if ($urandom_range(0, 9) == 0)
          add_request(OPC_LOAD, 3'($urandom), 6'($urandom), 6'($urandom),
                      rand_value(), rand_value());
        else
          add_request(OPC_LOAD, 3'($urandom), 6'($urandom), 6'($urandom),
                      rand_diag(), rand_diag());
      end else begin
        t = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
        add_request(OPC_SCALE, 3'(t), 6'($urandom), 6'($urandom), rand_value(), rand_value());
      end
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending_requests.size() == 0 && !in_valid);
    wait (scaled_expected.size() == 0);
    repeat (250) @(posedge clk);
    stimulus_done = 1;
    $display("Sent %0d loads and %0d scale requests; checked %0d results, %0d saturated.",
             loads_sent, scales_sent, results_seen, sat_seen);
    if (errors == 0 && scaled_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin
    bit took, nv;
    request_t r;
    took = in_valid && !in_stall;
    nv = 1'b0;
    if (!rst) begin
      if (took) begin
        apply_request(pending_requests.pop_front());
        send_gap = pick_gap();
      end
      if (in_valid && !took) begin
        nv = 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
      end else if (pending_requests.size() > 0) begin
        r = pending_requests[0];
        opcode <= r.opc;
        target_matrix <= r.tgt;
        row_index <= r.row;
        column_index <= r.col;
        first_value <= r.v1;
        second_value <= r.v2;
        nv = 1'b1;
      end
    end
    in_valid <= nv;
  end

  always @(posedge clk) begin
    scaled_t e;
    bit ns;
    ns = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (saturated_flag) sat_seen++;
        if (scaled_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, scaled_value);
        end else begin
          e = scaled_expected.pop_front();
          if (scaled_value !== e.val) begin
            errors++;
            $display("%0t: scaled_value expected %h actual %h", $time, e.val, scaled_value);
          end
          if (saturated_flag !== e.sat) begin
            errors++;
            $display("%0t: saturated_flag expected %b actual %b", $time, e.sat, saturated_flag);
          end
        end
        if (results_seen == 150 && !pressure_done) begin
          pressure_done = 1;
          hold_left = HOLD_LEN;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        ns = 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        ns = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        recv_gap = pick_gap();
        ns = (recv_gap > 0);
      end
    end
    out_stall <= ns;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT && !stimulus_done) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("FAIL");
      $finish;
    end
  end

endmodule
